@@ design/ludi_pkg.sv @@
`timescale 1ns / 1ps
// Package for the LU determinant / inverse block: sizes, memory regions and
// saturating add and subtract helpers. No dependencies.
package ludi_pkg;

    localparam int MAX_DIM   = 4;
    localparam int FRAC_DEF  = 16;
    localparam int IDX_W     = 2;
    localparam int CNT_W     = 3;
    localparam int REGION_W  = 3;
    localparam int ADDR_W    = REGION_W + 2 * IDX_W;
    localparam int REGIONS   = 5;
    localparam int MEM_DEPTH = REGIONS * (1 << (2 * IDX_W));

    localparam logic [REGION_W-1:0] RG_A   = 3'd0;
    localparam logic [REGION_W-1:0] RG_U   = 3'd1;
    localparam logic [REGION_W-1:0] RG_L   = 3'd2;
    localparam logic [REGION_W-1:0] RG_V   = 3'd3;
    localparam logic [REGION_W-1:0] RG_INV = 3'd4;

    localparam logic [IDX_W-1:0] V_FWD  = 2'd0;
    localparam logic [IDX_W-1:0] V_BACK = 2'd1;

    localparam logic [1:0] CFG_INVERT = 2'd0;
    localparam logic [1:0] CFG_SIZE   = 2'd1;
    localparam logic [1:0] CFG_THRESH = 2'd2;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef logic [32:0] t_qres;  // {clip, value}

    function automatic t_qres f_sat33(input logic signed [32:0] s);
        t_qres res;
        if (s > 33'sd2147483647) begin
            res = {1'b1, Q_MAX};
        end else if (s < -33'sd2147483648) begin
            res = {1'b1, Q_MIN};
        end else begin
            res = {1'b0, s[31:0]};
        end
        return res;
    endfunction

    function automatic t_qres f_add(input logic signed [31:0] a, input logic signed [31:0] b);
        return f_sat33(33'(a) + 33'(b));
    endfunction

    function automatic t_qres f_sub(input logic signed [31:0] a, input logic signed [31:0] b);
        return f_sat33(33'(a) - 33'(b));
    endfunction

    function automatic logic [31:0] f_mag(input logic signed [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [ADDR_W-1:0] f_addr(input logic [REGION_W-1:0] rg,
                                                input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c);
        return {rg, r[IDX_W-1:0], c[IDX_W-1:0]};
    endfunction

endpackage

@@ design/lu_determinant_inverse.sv @@
`timescale 1ns / 1ps
// Top level of the LU determinant / inverse block: sequencer, shared work
// memory, multiplier and iterative divider. Depends on ludi_pkg.
//
//  Channel  | Direction | Contents
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | element writes and start items
//  m_*      | out       | determinant, then inverse elements in row order
//  i_cfg_*  | in        | register writes: invert mode, size, threshold
//
// An element write is taken whenever the block is idle. A start item keeps
// the input closed until its run is done: every step goes through the single
// work memory (registered read), the product and rounding stages, and the
// bit-serial divider, which yields one quotient bit per iteration. Reset is
// synchronous and active low. A result waits in the output register until it
// is taken; the sequencer stalls while it waits.
module lu_determinant_inverse
    import ludi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] row_index, [3:2] col_index, [35:4] element_in, [39:36] zero
    input  logic [39:0] s_tdata,
    // [0] action
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] out_row, [3:2] out_col, [35:4] element_value, [39:36] zero
    output logic [39:0] m_tdata,
    // [0] is_determinant, [1] singular, [2] saturated
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    localparam int NW     = 32 + FRAC_BITS;
    localparam int DCNT_W = $clog2(NW + 1);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    localparam logic [5:0] S_IDLE = 6'd0,  S_CP_RD = 6'd1,  S_CP_WR = 6'd2;
    localparam logic [5:0] S_PV_INIT = 6'd3, S_PV_RD = 6'd4, S_PV_CMP = 6'd5;
    localparam logic [5:0] S_SW_RD = 6'd6, S_SW_W0 = 6'd7, S_SW_W1 = 6'd8;
    localparam logic [5:0] S_PIV_RD = 6'd9, S_PIV_GET = 6'd10;
    localparam logic [5:0] S_EL_RD = 6'd11, S_EL_OP = 6'd12, S_EL_WL = 6'd13;
    localparam logic [5:0] S_UP_RD = 6'd14, S_UP_OP = 6'd15, S_UP_WR = 6'd16;
    localparam logic [5:0] S_DT_INIT = 6'd17, S_DT_RD = 6'd18, S_DT_OP = 6'd19;
    localparam logic [5:0] S_DT_ACC = 6'd20, S_DT_FIN = 6'd21, S_DT_NX = 6'd22;
    localparam logic [5:0] S_FW_INIT = 6'd23, S_FW_CHK = 6'd24, S_FW_RD = 6'd25;
    localparam logic [5:0] S_FW_OP = 6'd26, S_FW_ACC = 6'd27, S_FW_WR = 6'd28;
    localparam logic [5:0] S_BK_INIT = 6'd29, S_BK_CHK = 6'd30, S_BK_RD = 6'd31;
    localparam logic [5:0] S_BK_OP = 6'd32, S_BK_ACC = 6'd33, S_BK_DRD = 6'd34;
    localparam logic [5:0] S_BK_DOP = 6'd35, S_BK_WR = 6'd36, S_BK_WI = 6'd37;
    localparam logic [5:0] S_EM_RD = 6'd38, S_EM_LD = 6'd39, S_EM_NX = 6'd40;
    localparam logic [5:0] S_OUT = 6'd41, S_MUL = 6'd42, S_RND = 6'd43;
    localparam logic [5:0] S_DIV_INIT = 6'd44, S_DIV_IT = 6'd45, S_DIV_FIN = 6'd46;

    // Saturating conversion of a magnitude and a sign to Q format.
    function automatic t_qres f_from_mag(input logic neg, input logic [63:0] m);
        t_qres res;
        if (!neg) begin
            if (m > 64'h7FFF_FFFF) res = {1'b1, Q_MAX};
            else res = {1'b0, m[31:0]};
        end else begin
            if (m > 64'h8000_0000) res = {1'b1, Q_MIN};
            else res = {1'b0, 32'd0 - m[31:0]};
        end
        return res;
    endfunction

    // Configuration registers.
    logic        r_invert;
    logic [2:0]  r_size;
    logic [30:0] r_thr;

    // Sequencer state.
    logic [5:0]  r_state, r_ret;
    logic [CNT_W-1:0] r_n, r_w, r_i, r_j, r_k;
    logic [REGION_W-1:0] r_reg;
    logic [31:0] r_best;
    logic [IDX_W-1:0] r_pr;
    logic [IDX_W-1:0] r_order [MAX_DIM];
    logic        r_sign;
    logic signed [31:0] r_piv, r_l, r_acc, r_det, r_tmp;
    logic        r_usable;
    logic        r_clip, r_fclip;
    logic [MAX_DIM-1:0] r_colclip;

    // Multiplier.
    logic signed [31:0] r_pa, r_pb, r_pq;
    logic [63:0] r_prod;
    logic        r_psign;

    // Divider.
    logic signed [31:0] r_da, r_db, r_dq;
    logic [31:0] r_dd;
    logic        r_dneg;
    logic [32:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DCNT_W-1:0] r_dcnt;

    // Output register.
    logic        r_ovalid, r_olast, r_odet, r_osing, r_osat;
    logic [IDX_W-1:0] r_orow, r_ocol;
    logic signed [31:0] r_oval;

    // Work memory: input matrix, U, L, solve vectors and inverse.
    logic [31:0] r_mem [0:MEM_DEPTH-1];
    logic [31:0] r_rd0, r_rd1;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra0, mem_ra1;
    logic [31:0] mem_wd;

    logic        in_acc;
    logic [IDX_W-1:0] in_row, in_col;
    logic [31:0] in_val;

    t_qres w_up, w_fw, w_acc, w_bd, w_rnd_q, w_div_q;
    logic [63:0] w_prod, w_rnd;
    logic [31:0] w_ma, w_mb, w_mrd0;
    logic signed [31:0] w_lval;
    logic [32:0] w_rs;
    logic        w_ge;
    logic        w_pv_gt;
    logic [IDX_W-1:0] w_pr_nx;
    logic [CNT_W-1:0] w_n_start;

    assign s_tready = (r_state == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_row   = s_tdata[1:0];
    assign in_col   = s_tdata[3:2];
    assign in_val   = s_tdata[35:4];

    assign m_tvalid = r_ovalid;
    assign m_tdata  = {4'd0, r_oval, r_ocol, r_orow};
    assign m_tuser  = {r_osat, r_osing, r_odet};
    assign m_tlast  = r_olast;

    // A size of zero acts as one; sizes above the maximum are clamped.
    assign w_n_start = (r_size == 3'd0) ? 3'd1 :
                       (r_size > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : r_size;

    assign w_ma    = f_mag(r_pa);
    assign w_mb    = f_mag(r_pb);
    assign w_prod  = w_ma * w_mb;
    assign w_rnd   = (r_prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign w_rnd_q = f_from_mag(r_psign, w_rnd);
    assign w_div_q = f_from_mag(r_dneg, 64'(r_quo));

    assign w_up    = f_sub(r_tmp, r_pq);
    assign w_fw    = f_sub((r_k == r_i) ? ONE : 32'sd0, r_acc);
    assign w_acc   = f_add(r_acc, r_pq);
    assign w_bd    = f_sub(r_rd0, r_acc);
    assign w_lval  = r_usable ? r_dq : 32'sd0;

    assign w_mrd0  = f_mag(r_rd0);
    assign w_pv_gt = w_mrd0 > r_best;
    assign w_pr_nx = w_pv_gt ? r_i[IDX_W-1:0] : r_pr;

    assign w_rs    = {r_rem[31:0], r_quo[NW-1]};
    assign w_ge    = w_rs >= {1'b0, r_dd};

    // Memory port control for each sequencer step.
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = '0;
        mem_ra0 = '0;
        mem_ra1 = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && !s_tuser[0] && ({1'b0, in_row} < CNT_W'(MAX_DIM))
                        && ({1'b0, in_col} < CNT_W'(MAX_DIM))) begin
                    mem_we = 1'b1;
                    mem_wa = f_addr(RG_A, {1'b0, in_row}, {1'b0, in_col});
                    mem_wd = in_val;
                end
            end
            S_CP_RD:  mem_ra0 = f_addr(RG_A, r_i, r_j);
            S_CP_WR: begin
                mem_we = 1'b1;
                mem_wa = f_addr(RG_U, r_i, r_j);
                mem_wd = r_rd0;
            end
            S_PV_RD:  mem_ra0 = f_addr(RG_U, r_i, r_w);
            S_SW_RD: begin
                mem_ra0 = f_addr(r_reg, r_w, r_j);
                mem_ra1 = f_addr(r_reg, {1'b0, r_pr}, r_j);
            end
            S_SW_W0: begin
                mem_we = 1'b1;
                mem_wa = f_addr(r_reg, r_w, r_j);
                mem_wd = r_rd1;
            end
            S_SW_W1: begin
                mem_we = 1'b1;
                mem_wa = f_addr(r_reg, {1'b0, r_pr}, r_j);
                mem_wd = r_tmp;
            end
            S_PIV_RD: mem_ra0 = f_addr(RG_U, r_w, r_w);
            S_EL_RD:  mem_ra0 = f_addr(RG_U, r_i, r_w);
            S_EL_WL: begin
                mem_we = 1'b1;
                mem_wa = f_addr(RG_L, r_i, r_w);
                mem_wd = w_lval;
            end
            S_UP_RD: begin
                mem_ra0 = f_addr(RG_U, r_w, r_j);
                mem_ra1 = f_addr(RG_U, r_i, r_j);
            end
            S_UP_WR: begin
                mem_we = 1'b1;
                mem_wa = f_addr(RG_U, r_i, r_j);
                mem_wd = w_up[31:0];
            end
            S_DT_RD:  mem_ra0 = f_addr(RG_U, r_i, r_i);
            S_FW_RD: begin
                mem_ra0 = f_addr(RG_L, r_i, r_j);
                mem_ra1 = f_addr(RG_V, {1'b0, V_FWD}, r_j);
            end
            S_FW_WR: begin
                mem_we = 1'b1;
                mem_wa = f_addr(RG_V, {1'b0, V_FWD}, r_i);
                mem_wd = w_fw[31:0];
            end
            S_BK_RD: begin
                mem_ra0 = f_addr(RG_U, r_i, r_j);
                mem_ra1 = f_addr(RG_V, {1'b0, V_BACK}, r_j);
            end
            S_BK_DRD: begin
                mem_ra0 = f_addr(RG_V, {1'b0, V_FWD}, r_i);
                mem_ra1 = f_addr(RG_U, r_i, r_i);
            end
            S_BK_WR: begin
                mem_we = 1'b1;
                mem_wa = f_addr(RG_V, {1'b0, V_BACK}, r_i);
                mem_wd = r_dq;
            end
            S_BK_WI: begin
                // Solved column k lands in inverse column row_order[k].
                mem_we = 1'b1;
                mem_wa = f_addr(RG_INV, r_i, {1'b0, r_order[r_k[IDX_W-1:0]]});
                mem_wd = r_dq;
            end
            S_EM_RD:  mem_ra0 = f_addr(RG_INV, r_i, r_j);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd0 <= r_mem[mem_ra0];
        r_rd1 <= r_mem[mem_ra1];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b1;
            r_size   <= 3'd4;
            r_thr    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INVERT: r_invert <= i_cfg_data[0];
                CFG_SIZE:   r_size   <= i_cfg_data[2:0];
                CFG_THRESH: r_thr    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sign   <= 1'b0;
            r_clip   <= 1'b0;
            for (int q = 0; q < MAX_DIM; q++) begin
                r_order[q] <= IDX_W'(q);
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && s_tuser[0]) begin
                        r_n    <= w_n_start;
                        r_clip <= 1'b0;
                        r_sign <= 1'b0;
                        for (int q = 0; q < MAX_DIM; q++) begin
                            r_order[q] <= IDX_W'(q);
                        end
                        r_i     <= '0;
                        r_j     <= '0;
                        r_w     <= '0;
                        r_state <= S_CP_RD;
                    end
                end
                S_CP_RD: r_state <= S_CP_WR;
                S_CP_WR: begin
                    r_state <= S_CP_RD;
                    if (r_j + 1'b1 == r_n) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_n) begin
                            r_state <= (r_n == 3'd1) ? S_DT_INIT : S_PV_INIT;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                // Pivot search: the first row with the largest magnitude wins.
                S_PV_INIT: begin
                    r_best  <= '0;
                    r_pr    <= r_w[IDX_W-1:0];
                    r_i     <= r_w;
                    r_state <= S_PV_RD;
                end
                S_PV_RD: r_state <= S_PV_CMP;
                S_PV_CMP: begin
                    if (w_pv_gt) begin
                        r_best <= w_mrd0;
                    end
                    r_pr <= w_pr_nx;
                    r_i  <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_n) begin
                        if (w_pr_nx != r_w[IDX_W-1:0]) begin
                            r_sign <= ~r_sign;
                            r_order[r_w[IDX_W-1:0]] <= r_order[w_pr_nx];
                            r_order[w_pr_nx]        <= r_order[r_w[IDX_W-1:0]];
                            r_reg   <= RG_U;
                            r_j     <= '0;
                            r_state <= S_SW_RD;
                        end else begin
                            r_state <= S_PIV_RD;
                        end
                    end else begin
                        r_state <= S_PV_RD;
                    end
                end
                // Row swap of U over all columns, then of L left of the pivot.
                S_SW_RD: r_state <= S_SW_W0;
                S_SW_W0: begin
                    r_tmp   <= r_rd0;
                    r_state <= S_SW_W1;
                end
                S_SW_W1: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= S_SW_RD;
                    if (r_reg == RG_U) begin
                        if (r_j + 1'b1 == r_n) begin
                            r_j <= '0;
                            if (r_w != '0) begin
                                r_reg <= RG_L;
                            end else begin
                                r_state <= S_PIV_RD;
                            end
                        end
                    end else if (r_j + 1'b1 == r_w) begin
                        r_state <= S_PIV_RD;
                    end
                end
                S_PIV_RD: r_state <= S_PIV_GET;
                S_PIV_GET: begin
                    r_piv    <= r_rd0;
                    r_usable <= w_mrd0 > {1'b0, r_thr};
                    r_i      <= r_w + 1'b1;
                    r_state  <= S_EL_RD;
                end
                S_EL_RD: r_state <= S_EL_OP;
                S_EL_OP: begin
                    if (r_usable) begin
                        r_da    <= r_rd0;
                        r_db    <= r_piv;
                        r_ret   <= S_EL_WL;
                        r_state <= S_DIV_INIT;
                    end else begin
                        r_state <= S_EL_WL;
                    end
                end
                S_EL_WL: begin
                    r_l     <= w_lval;
                    r_j     <= '0;
                    r_state <= S_UP_RD;
                end
                S_UP_RD: r_state <= S_UP_OP;
                S_UP_OP: begin
                    r_pa    <= r_rd0;
                    r_pb    <= r_l;
                    r_tmp   <= r_rd1;
                    r_ret   <= S_UP_WR;
                    r_state <= S_MUL;
                end
                S_UP_WR: begin
                    r_clip  <= r_clip | w_up[32];
                    r_state <= S_UP_RD;
                    if (r_j + 1'b1 == r_n) begin
                        r_j     <= '0;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_EL_RD;
                        if (r_i + 1'b1 == r_n) begin
                            r_w     <= r_w + 1'b1;
                            r_state <= (r_w + 2'd2 == r_n) ? S_DT_INIT : S_PV_INIT;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                // Determinant: signed product of the pivots.
                S_DT_INIT: begin
                    r_fclip <= r_clip;
                    r_det   <= r_sign ? -ONE : ONE;
                    r_i     <= '0;
                    r_state <= S_DT_RD;
                end
                S_DT_RD: r_state <= S_DT_OP;
                S_DT_OP: begin
                    r_pa    <= r_det;
                    r_pb    <= r_rd0;
                    r_ret   <= S_DT_ACC;
                    r_state <= S_MUL;
                end
                S_DT_ACC: begin
                    r_det   <= r_pq;
                    r_i     <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 == r_n) ? S_DT_FIN : S_DT_RD;
                end
                S_DT_FIN: begin
                    r_ovalid <= 1'b1;
                    r_orow   <= '0;
                    r_ocol   <= '0;
                    r_oval   <= r_det;
                    r_odet   <= 1'b1;
                    r_osing  <= f_mag(r_det) <= {1'b0, r_thr};
                    r_osat   <= r_clip;
                    r_olast  <= !r_invert || (f_mag(r_det) <= {1'b0, r_thr});
                    r_ret    <= S_DT_NX;
                    r_state  <= S_OUT;
                end
                S_DT_NX: begin
                    if (r_olast) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clip  <= r_fclip;
                        r_k     <= '0;
                        r_i     <= '0;
                        r_state <= S_FW_INIT;
                    end
                end
                // Forward substitution with the unit lower factor.
                S_FW_INIT: begin
                    r_acc   <= '0;
                    r_j     <= '0;
                    r_state <= S_FW_CHK;
                end
                S_FW_CHK: r_state <= (r_j < r_i) ? S_FW_RD : S_FW_WR;
                S_FW_RD:  r_state <= S_FW_OP;
                S_FW_OP: begin
                    r_pa    <= r_rd0;
                    r_pb    <= r_rd1;
                    r_ret   <= S_FW_ACC;
                    r_state <= S_MUL;
                end
                S_FW_ACC: begin
                    r_acc   <= w_acc[31:0];
                    r_clip  <= r_clip | w_acc[32];
                    r_j     <= r_j + 1'b1;
                    r_state <= S_FW_CHK;
                end
                S_FW_WR: begin
                    r_clip <= r_clip | w_fw[32];
                    if (r_i + 1'b1 == r_n) begin
                        r_i     <= r_n - 1'b1;
                        r_state <= S_BK_INIT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_FW_INIT;
                    end
                end
                // Back substitution with the upper factor, last row first.
                S_BK_INIT: begin
                    r_acc   <= '0;
                    r_j     <= r_i + 1'b1;
                    r_state <= S_BK_CHK;
                end
                S_BK_CHK: r_state <= (r_j < r_n) ? S_BK_RD : S_BK_DRD;
                S_BK_RD:  r_state <= S_BK_OP;
                S_BK_OP: begin
                    r_pa    <= r_rd0;
                    r_pb    <= r_rd1;
                    r_ret   <= S_BK_ACC;
                    r_state <= S_MUL;
                end
                S_BK_ACC: begin
                    r_acc   <= w_acc[31:0];
                    r_clip  <= r_clip | w_acc[32];
                    r_j     <= r_j + 1'b1;
                    r_state <= S_BK_CHK;
                end
                S_BK_DRD: r_state <= S_BK_DOP;
                S_BK_DOP: begin
                    r_da    <= w_bd[31:0];
                    r_clip  <= r_clip | w_bd[32];
                    r_db    <= r_rd1;
                    r_ret   <= S_BK_WR;
                    r_state <= S_DIV_INIT;
                end
                S_BK_WR: r_state <= S_BK_WI;
                S_BK_WI: begin
                    if (r_i == '0) begin
                        r_colclip[r_order[r_k[IDX_W-1:0]]] <= r_clip;
                        r_i <= '0;
                        if (r_k + 1'b1 == r_n) begin
                            r_j     <= '0;
                            r_state <= S_EM_RD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_clip  <= r_fclip;
                            r_state <= S_FW_INIT;
                        end
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_BK_INIT;
                    end
                end
                // Emission of the inverse in row-major order.
                S_EM_RD: r_state <= S_EM_LD;
                S_EM_LD: begin
                    r_ovalid <= 1'b1;
                    r_orow   <= r_i[IDX_W-1:0];
                    r_ocol   <= r_j[IDX_W-1:0];
                    r_oval   <= r_rd0;
                    r_odet   <= 1'b0;
                    r_osing  <= 1'b0;
                    r_osat   <= r_colclip[r_j[IDX_W-1:0]];
                    r_olast  <= (r_i + 1'b1 == r_n) && (r_j + 1'b1 == r_n);
                    r_ret    <= S_EM_NX;
                    r_state  <= S_OUT;
                end
                S_EM_NX: begin
                    if (r_olast) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EM_RD;
                        if (r_j + 1'b1 == r_n) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= r_ret;
                    end
                end
                // Product of magnitudes, then rounding and saturation.
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_psign <= r_pa[31] ^ r_pb[31];
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_pq    <= w_rnd_q[31:0];
                    r_clip  <= r_clip | w_rnd_q[32];
                    r_state <= r_ret;
                end
                // Restoring divider, one quotient bit per cycle.
                S_DIV_INIT: begin
                    if (r_db == '0) begin
                        r_dq    <= (r_da == '0) ? 32'sd0 : (r_da[31] ? Q_MIN : Q_MAX);
                        r_clip  <= r_clip | (r_da != '0);
                        r_state <= r_ret;
                    end else begin
                        r_dd    <= f_mag(r_db);
                        r_dneg  <= r_da[31] ^ r_db[31];
                        r_rem   <= '0;
                        r_quo   <= (NW'(f_mag(r_da)) << FRAC_BITS) + NW'(f_mag(r_db) >> 1);
                        r_dcnt  <= DCNT_W'(NW);
                        r_state <= S_DIV_IT;
                    end
                end
                S_DIV_IT: begin
                    r_rem   <= w_ge ? (w_rs - {1'b0, r_dd}) : w_rs;
                    r_quo   <= {r_quo[NW-2:0], w_ge};
                    r_dcnt  <= r_dcnt - 1'b1;
                    r_state <= (r_dcnt == DCNT_W'(1)) ? S_DIV_FIN : S_DIV_IT;
                end
                S_DIV_FIN: begin
                    r_dq    <= w_div_q[31:0];
                    r_clip  <= r_clip | w_div_q[32];
                    r_state <= r_ret;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lu_determinant_inverse: it loads matrices, starts
// runs and checks the determinant and inverse stream against its own LU model.
// Depends on ludi_pkg and the design files.
module testbench;
    import ludi_pkg::*;

    localparam int           CLK_HALF   = 6;
    localparam int           RST_CYCLES = 12;
    localparam longint       CYCLE_CAP  = 3000000;
    localparam int           SETTLE     = 64;
    localparam int           ITEMS_PER_PHASE = 36;
    localparam logic [1:0]   CFG_NONE   = 2'd3;
    localparam logic [0:0]   ACT_WRITE  = 1'b0;
    localparam logic [0:0]   ACT_START  = 1'b1;
    localparam longint       QHI  = 64'sd2147483647;
    localparam longint       QLO  = -64'sd2147483648;
    localparam longint       UNIT = 64'sd1 << FRAC_DEF;
    localparam logic [31:0]  ELEM_ONE = 32'h0001_0000;

    // One expected or observed result of a run.
    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        is_det;
        logic        singular;
        logic        saturated;
        logic        last;
    } t_elem;

    // The scoreboard holds a private copy of the matrix state and the registers.
    // Every accepted input transfer goes through note_input, which works out
    // the results of a start; check_result compares each output transfer with
    // the oldest result still waiting.
    class lu_result_board;
        longint   mat [16];
        longint   up  [16];
        longint   lo  [16];
        int       order [4];
        bit       neg_sign;
        longint   fwd [4];
        longint   bck [4];
        bit       clip;
        bit       inv_mode;
        int       dim_reg;
        longint   thresh;
        t_elem    waiting_elems [$];
        int       mismatches;

        function new();
            for (int i = 0; i < 16; i++) begin
                mat[i] = 0;
                up[i]  = 0;
                lo[i]  = 0;
            end
            for (int i = 0; i < 4; i++) begin
                order[i] = i;
                fwd[i]   = 0;
                bck[i]   = 0;
            end
            neg_sign   = 0;
            clip       = 0;
            inv_mode   = 1;
            dim_reg    = 4;
            thresh     = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [30:0] data);
            case (idx)
                CFG_INVERT: inv_mode = data[0];
                CFG_SIZE:   dim_reg  = int'(data[2:0]);
                CFG_THRESH: thresh   = longint'(data);
                default: ;
            endcase
        endfunction

        function int cur_dim();
            if (dim_reg < 1) return 1;
            if (dim_reg > MAX_DIM) return MAX_DIM;
            return dim_reg;
        endfunction

        function longint magn(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint from_mag(bit neg, longint m);
            if (!neg) begin
                if (m > QHI) begin
                    clip = 1;
                    return QHI;
                end
                return m;
            end
            if (m > QHI + 1) begin
                clip = 1;
                return QLO;
            end
            return -m;
        endfunction

        function longint sat(longint s);
            if (s > QHI) begin
                clip = 1;
                return QHI;
            end
            if (s < QLO) begin
                clip = 1;
                return QLO;
            end
            return s;
        endfunction

        // Exact product, rounded half away from zero, then scaled back.
        function longint qmul(longint a, longint b);
            longint m;
            m = magn(a) * magn(b);
            m = (m + (64'sd1 << (FRAC_DEF - 1))) >>> FRAC_DEF;
            return from_mag((a < 0) != (b < 0), m);
        endfunction

        function longint qdiv(longint a, longint b);
            longint d;
            longint m;
            if (b == 0) begin
                if (a == 0) return 0;
                clip = 1;
                return (a < 0) ? QLO : QHI;
            end
            d = magn(b);
            m = ((magn(a) <<< FRAC_DEF) + d / 2) / d;
            return from_mag((a < 0) != (b < 0), m);
        endfunction

        function void factorise(int n);
            longint best;
            longint piv;
            longint t;
            longint l;
            int     pr;
            int     tmp;
            bit     usable;
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    up[i*4+j] = mat[i*4+j];
                    lo[i*4+j] = (i == j) ? UNIT : 0;
                end
                order[i] = i;
            end
            neg_sign = 0;
            for (int w = 0; w < n - 1; w++) begin
                best = 0;
                pr   = w;
                // The first row holding the largest magnitude wins the pivot.
                for (int i = w; i < n; i++) begin
                    if (magn(up[i*4+w]) > best) begin
                        best = magn(up[i*4+w]);
                        pr   = i;
                    end
                end
                if (pr != w) begin
                    neg_sign = ~neg_sign;
                    for (int j = 0; j < n; j++) begin
                        t           = up[w*4+j];
                        up[w*4+j]   = up[pr*4+j];
                        up[pr*4+j]  = t;
                    end
                    tmp       = order[w];
                    order[w]  = order[pr];
                    order[pr] = tmp;
                    for (int j = 0; j < w; j++) begin
                        t          = lo[w*4+j];
                        lo[w*4+j]  = lo[pr*4+j];
                        lo[pr*4+j] = t;
                    end
                end
                piv    = up[w*4+w];
                usable = magn(piv) > thresh;
                for (int i = w + 1; i < n; i++) begin
                    l = usable ? qdiv(up[i*4+w], piv) : 0;
                    lo[i*4+w] = l;
                    for (int j = 0; j < n; j++)
                        up[i*4+j] = sat(up[i*4+j] - qmul(up[w*4+j], l));
                end
            end
        endfunction

        function void push(int r, int c, longint v, bit d, bit s, bit st, bit lst);
            t_elem e;
            e.row       = r[1:0];
            e.col       = c[1:0];
            e.value     = v[31:0];
            e.is_det    = d;
            e.singular  = s;
            e.saturated = st;
            e.last      = lst;
            waiting_elems.push_back(e);
        endfunction

        function void predict_run();
            int     n;
            int     c;
            bit     fclip;
            bit     dclip;
            bit     sing;
            longint det;
            longint acc;
            longint inv [16];
            bit     iclip [16];
            n     = cur_dim();
            clip  = 0;
            factorise(n);
            fclip = clip;
            det   = neg_sign ? -UNIT : UNIT;
            for (int i = 0; i < n; i++) det = qmul(det, up[i*4+i]);
            dclip = clip;
            sing  = magn(det) <= thresh;
            if (!inv_mode || sing) begin
                push(0, 0, det, 1, sing, dclip, 1);
                return;
            end
            push(0, 0, det, 1, 0, dclip, 0);
            for (int k = 0; k < n; k++) begin
                clip = fclip;
                for (int i = 0; i < n; i++) begin
                    acc = 0;
                    for (int j = 0; j < i; j++)
                        acc = sat(acc + qmul(lo[i*4+j], fwd[j]));
                    fwd[i] = sat(((i == k) ? UNIT : 0) - acc);
                end
                for (int i = n - 1; i >= 0; i--) begin
                    acc = 0;
                    for (int j = i + 1; j < n; j++)
                        acc = sat(acc + qmul(up[i*4+j], bck[j]));
                    bck[i] = qdiv(sat(fwd[i] - acc), up[i*4+i]);
                end
                c = order[k];
                for (int i = 0; i < n; i++) begin
                    inv[i*4+c]   = bck[i];
                    iclip[i*4+c] = clip;
                end
            end
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    push(i, j, inv[i*4+j], 0, 0, iclip[i*4+j],
                         (i == n - 1) && (j == n - 1));
        endfunction

        function void note_input(logic [0:0] act, logic [39:0] data);
            if (act == ACT_WRITE)
                mat[data[1:0]*4 + data[3:2]] = longint'(signed'(data[35:4]));
            else
                predict_run();
        endfunction

        function void check_result(t_elem got);
            t_elem exp_e;
            if (waiting_elems.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: row %0d col %0d value %h",
                             got.row, got.col, got.value);
                return;
            end
            exp_e = waiting_elems.pop_front();
            if (got !== exp_e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected row %0d col %0d value %h det %b sing %b ",
                              "sat %b last %b, got row %0d col %0d value %h det %b ",
                              "sing %b sat %b last %b"},
                             exp_e.row, exp_e.col, exp_e.value, exp_e.is_det,
                             exp_e.singular, exp_e.saturated, exp_e.last,
                             got.row, got.col, got.value, got.is_det,
                             got.singular, got.saturated, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [30:0] i_cfg_data;

    lu_result_board board;
    longint         cycles;
    int             hold_cycles;
    int             burst_left;
    bit             gapless;

    lu_determinant_inverse DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Both monitors sample at the clock edge, before the design updates.
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready)
            board.note_input(s_tuser, s_tdata);
    end

    always @(posedge i_clk) begin
        t_elem got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.row       = m_tdata[1:0];
            got.col       = m_tdata[3:2];
            got.value     = m_tdata[35:4];
            got.is_det    = m_tuser[0];
            got.singular  = m_tuser[1];
            got.saturated = m_tuser[2];
            got.last      = m_tlast;
            board.check_result(got);
        end
    end

    // The receiver cycles through a full-rate stretch, random stalls and a
    // fixed pattern. A hold-off request from the main flow overrides it.
    initial begin
        int step;
        step = 0;
        forever begin
            @(posedge i_clk);
            step++;
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                case ((step / 300) % 3)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 2) != 0);
                    default: m_tready <= ((step % 7) < 3);
                endcase
            end
        end
    end

    // One input transfer. The sender works in bursts; a gap lowers tvalid only
    // when the gap is not empty, so tvalid is never dropped and raised again
    // within the same time step.
    task automatic send_item(logic [0:0] act, logic [1:0] row, logic [1:0] col,
                             logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = gapless ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, value, col, row};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic start_run();
        send_item(ACT_START, 2'($urandom), 2'($urandom), $urandom);
    endtask

    // Drop the input, wait for every expected result, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.waiting_elems.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // The write enable is lowered again after each write, before the task returns.
    task automatic write_reg(logic [1:0] idx, logic [30:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_elem();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2, 3: v = $urandom;
            default: begin
                v = $urandom_range(0, 6 << FRAC_DEF);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    initial begin
        int          n;
        int          cnt;
        int          pick;
        logic [30:0] thr;
        logic [2:0]  sz;
        board       = new();
        hold_cycles = 0;
        burst_left  = 0;
        gapless     = 0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_WRITE;
        m_tready    = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_INVERT;
        i_cfg_data  = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Every cell is written first so that no run ever reads
        // an element that was never loaded. Extreme values on the diagonal
        // force clipping in the determinant.
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_item(ACT_WRITE, 2'(r), 2'(c),
                          (r != c) ? 32'h0 :
                          (r == 0) ? 32'h7FFF_FFFF :
                          (r == 1) ? 32'h8000_0000 : ELEM_ONE);
        send_item(ACT_START, 2'b11, 2'b11, 32'hFFFF_FFFF);
        // A zero first column: zero pivot, zero multipliers, singular result.
        send_item(ACT_WRITE, 2'd0, 2'd0, 32'h0);
        send_item(ACT_WRITE, 2'd1, 2'd0, 32'h0);
        start_run();
        // A row swap is needed for the largest pivot.
        send_item(ACT_WRITE, 2'd1, 2'd0, 32'h0003_0000);
        send_item(ACT_WRITE, 2'd0, 2'd0, 32'h0001_0000);
        send_item(ACT_WRITE, 2'd1, 2'd1, 32'hFFFE_0000);
        start_run();
        drain();
        write_reg(CFG_NONE, 31'h7FFF_FFFF);
        write_reg(CFG_INVERT, 31'd0);
        start_run();
        drain();

        // Random phases, each under its own register setting. Most items form
        // complete matrices followed by a start; the rest are stray writes
        // and bare starts.
        for (int p = 0; p < 10; p++) begin
            drain();
            case (p)
                0: begin sz = 3'd4; thr = 31'd0;          end
                1: begin sz = 3'd1; thr = 31'd0;          end
                2: begin sz = 3'd2; thr = 31'h100;        end
                3: begin sz = 3'd0; thr = 31'h7FFF_FFFF;  end
                4: begin sz = 3'd3; thr = 31'd0;          end
                5: begin sz = 3'd7; thr = 31'h40;         end
                6: begin sz = 3'd5; thr = 31'h1_0000;     end
                7: begin sz = 3'd4; thr = 31'h2AAA_5555;  end
                8: begin sz = 3'd2; thr = 31'($urandom);  end
                default: begin sz = 3'd6; thr = 31'd0;    end
            endcase
            write_reg(CFG_INVERT, (p % 4 == 3) ? 31'd0 : 31'd1);
            write_reg(CFG_SIZE, {28'd0, sz});
            write_reg(CFG_THRESH, thr);
            if (p % 3 == 0) write_reg(CFG_NONE, 31'($urandom));
            gapless = (p % 3 == 1);
            // Long receiver hold-off while the sender keeps offering items.
            if (p == 0) hold_cycles = 4000;
            n   = board.cur_dim();
            cnt = 0;
            while (cnt < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    for (int r = 0; r < n; r++)
                        for (int c = 0; c < n; c++)
                            send_item(ACT_WRITE, 2'(r), 2'(c), rand_elem());
                    start_run();
                    cnt += n * n + 1;
                end else if (pick == 8) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(ACT_WRITE, 2'($urandom), 2'($urandom), $urandom);
                        cnt++;
                    end
                end else begin
                    start_run();
                    cnt++;
                end
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0 && board.waiting_elems.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
